FILE: rtl/sprite_frame_sequencer_macros.svh
// Assertion macros for the sprite frame sequencer.
// Included by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef SPRITE_FRAME_SEQUENCER_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define SFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite_frame_sequencer assertion failed");
`define SFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite_frame_sequencer assertion failed");
`else
`define SFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/sfs_pkg.sv
// Package for the sprite frame sequencer: payload structs, codes and the
// microcode table. No dependencies.
package sfs_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int CELL_BITS_DEF  = 12;

  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int DND_W     = 33;
  localparam int DVS_W     = 16;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_N = DIV_CNT_W'(DND_W);

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_RESTART = 2'd1;
  localparam logic [1:0] MODE_LOAD    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLUMNS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] elapsed;
    logic [5:0]  entry_index;
    logic [11:0] entry_cell;
  } in_item_t;

  typedef struct packed {
    logic [19:0] src_x;
    logic [23:0] src_y;
    logic [5:0]  frame_position;
    logic        shown;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_ADD_TIME,
    OP_DIV_TIME,
    OP_DIV_STEP,
    OP_STEPS,
    OP_DIV_POS,
    OP_POS_WRAP,
    OP_STOP,
    OP_HOLD,
    OP_APPLY,
    OP_READ,
    OP_DIV_CELL,
    OP_MUL,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_NOT_TICK,
    C_SKIP_ADV,
    C_QUOT_ZERO,
    C_NO_LOOP,
    C_DIV_MORE,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  localparam logic [STEP_W-1:0] ST_TAKE     = 5'd0;
  localparam logic [STEP_W-1:0] ST_DISPATCH = 5'd1;
  localparam logic [STEP_W-1:0] ST_ADD      = 5'd2;
  localparam logic [STEP_W-1:0] ST_TDIV     = 5'd3;
  localparam logic [STEP_W-1:0] ST_TDIV_RUN = 5'd4;
  localparam logic [STEP_W-1:0] ST_STEPS    = 5'd5;
  localparam logic [STEP_W-1:0] ST_LOOPCHK  = 5'd6;
  localparam logic [STEP_W-1:0] ST_PDIV     = 5'd7;
  localparam logic [STEP_W-1:0] ST_PDIV_RUN = 5'd8;
  localparam logic [STEP_W-1:0] ST_WRAP     = 5'd9;
  localparam logic [STEP_W-1:0] ST_STOP     = 5'd10;
  localparam logic [STEP_W-1:0] ST_HOLD     = 5'd11;
  localparam logic [STEP_W-1:0] ST_APPLY    = 5'd12;
  localparam logic [STEP_W-1:0] ST_READ     = 5'd13;
  localparam logic [STEP_W-1:0] ST_CDIV     = 5'd14;
  localparam logic [STEP_W-1:0] ST_CDIV_RUN = 5'd15;
  localparam logic [STEP_W-1:0] ST_MUL      = 5'd16;
  localparam logic [STEP_W-1:0] ST_EMIT     = 5'd17;
  localparam logic [STEP_W-1:0] ST_RETURN   = 5'd18;

  function automatic ctrl_word_t ucode_rom(logic [STEP_W-1:0] addr);
    ctrl_word_t cw;
    unique case (addr)
      ST_TAKE:     cw = '{OP_TAKE,     C_NO_ITEM,   ST_TAKE};
      ST_DISPATCH: cw = '{OP_NOP,      C_NOT_TICK,  ST_APPLY};
      ST_ADD:      cw = '{OP_ADD_TIME, C_SKIP_ADV,  ST_READ};
      ST_TDIV:     cw = '{OP_DIV_TIME, C_NEVER,     ST_TAKE};
      ST_TDIV_RUN: cw = '{OP_DIV_STEP, C_DIV_MORE,  ST_TDIV_RUN};
      ST_STEPS:    cw = '{OP_STEPS,    C_QUOT_ZERO, ST_READ};
      ST_LOOPCHK:  cw = '{OP_NOP,      C_NO_LOOP,   ST_STOP};
      ST_PDIV:     cw = '{OP_DIV_POS,  C_NEVER,     ST_TAKE};
      ST_PDIV_RUN: cw = '{OP_DIV_STEP, C_DIV_MORE,  ST_PDIV_RUN};
      ST_WRAP:     cw = '{OP_POS_WRAP, C_ALWAYS,    ST_READ};
      ST_STOP:     cw = '{OP_STOP,     C_NEVER,     ST_TAKE};
      ST_HOLD:     cw = '{OP_HOLD,     C_ALWAYS,    ST_READ};
      ST_APPLY:    cw = '{OP_APPLY,    C_NEVER,     ST_TAKE};
      ST_READ:     cw = '{OP_READ,     C_NEVER,     ST_TAKE};
      ST_CDIV:     cw = '{OP_DIV_CELL, C_NEVER,     ST_TAKE};
      ST_CDIV_RUN: cw = '{OP_DIV_STEP, C_DIV_MORE,  ST_CDIV_RUN};
      ST_MUL:      cw = '{OP_MUL,      C_NEVER,     ST_TAKE};
      ST_EMIT:     cw = '{OP_EMIT,     C_OUT_FULL,  ST_EMIT};
      ST_RETURN:   cw = '{OP_NOP,      C_ALWAYS,    ST_TAKE};
      default:     cw = '{OP_NOP,      C_ALWAYS,    ST_TAKE};
    endcase
    return cw;
  endfunction

endpackage

FILE: rtl/sprite_frame_sequencer.sv
// Sprite frame sequencer: microcoded control over a shared restoring
// divider, three small multipliers and the frame table memory.
// Depends on sfs_pkg and sprite_frame_sequencer_macros.svh.
//
// Usage:
//   in_*  : one transaction per item (tick, restart, load); in_ready is high
//           only while the sequencer waits at its first microcode step.
//   out_* : exactly one result transaction per accepted item, held in an
//           output register until out_ready takes it.
//   cfg_* : register writes, always ready; write only while the block is idle.
// Timing: in_ready returns only once the previous result is in the output register.
//   Every item runs the cell split; a tick that advances also runs the time split
//   and, given a frame step, the stop and hold steps (holding clip) or the wrap
//   split (looping clip). Each divider pass is a load and 33 shift steps: one pass
//   for the cell split, one for the time split, one for the wrap.
//   The result becomes valid in the cycle before in_ready returns.
// Reset: synchronous, active low; clears position, timer, active flag and
//   registers to their reset values. Table contents stay undefined until loaded.
// Stall: while out_valid waits, the next item may be accepted and worked on;
//   the sequencer holds at its emit step until the output register is free.
`include "sprite_frame_sequencer_macros.svh"

module sprite_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int CELL_BITS  = CELL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int POS_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int LEN_W  = $clog2(MAX_FRAMES + 1);
  localparam int PROD_W = LEN_W + 16;
  localparam int YP_W   = CELL_BITS + 12;

  logic [STEP_W-1:0]    step_r, step_nxt;
  ctrl_word_t           cw;
  logic                 jump;

  logic [15:0]          frame_period_r;
  logic                 loop_enable_r;
  logic [6:0]           clip_length_r;
  logic [7:0]           sheet_columns_r;
  logic [11:0]          frame_width_r;
  logic [11:0]          frame_height_r;

  in_item_t             item_r;
  logic [POS_W-1:0]     pos_r;
  logic [31:0]          acc_r;
  logic                 active_r;
  logic [31:0]          sum_r;
  logic [31:0]          steps_r;
  logic [PROD_W-1:0]    prod_r;
  logic                 ge_r;

  logic [DND_W-1:0]     dnd_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [CELL_BITS-1:0] frame_table [MAX_FRAMES];
  logic [CELL_BITS-1:0] rd_r;

  logic [19:0]          x_prod_r;
  logic [23:0]          y_prod_r;
  logic                 out_valid_r;
  out_item_t            out_r;

  logic [31:0]          len_full;
  logic [LEN_W-1:0]     len;
  logic                 pos_lt_len;
  logic [POS_W-1:0]     rd_addr;
  logic [32:0]          time_sum;
  logic [31:0]          time_sat;
  logic [LEN_W-1:0]     stop_v;
  logic [PROD_W-1:0]    prod_v;
  logic [DND_W-1:0]     pos_dnd;
  logic [17:0]          trial;
  logic                 trial_ok;
  logic [31:0]          pos32;
  logic [31:0]          cell32;
  logic [19:0]          x_full;
  logic [YP_W-1:0]      y_full;
  logic [31:0]          y32;
  logic                 show;
  logic                 load_ok;

  assign cw        = ucode_rom(step_r);
  assign in_ready  = (cw.op == OP_TAKE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    len_full   = (32'(clip_length_r) > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES)
                                                        : 32'(clip_length_r);
    len        = len_full[LEN_W-1:0];
    pos32      = 32'(pos_r);
    pos_lt_len = pos32 < 32'(len);
    rd_addr    = pos_lt_len ? pos_r : POS_W'(len - LEN_W'(1));
    time_sum   = {1'b0, acc_r} + 33'(item_r.elapsed);
    time_sat   = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
    stop_v     = pos_lt_len ? (len - LEN_W'(pos_r)) : LEN_W'(1);
    prod_v     = PROD_W'(stop_v) * PROD_W'(frame_period_r);
    pos_dnd    = pos_lt_len ? (33'(pos_r) + 33'(steps_r)) : (33'(steps_r) - 33'd1);
    trial      = {1'b0, rem_r, dnd_r[DND_W-1]} - {2'b00, dvs_r};
    trial_ok   = !trial[17];
    cell32     = 32'(item_r.entry_cell);
    x_full     = 20'(rem_r[7:0]) * 20'(frame_width_r);
    y_full     = YP_W'(dnd_r[CELL_BITS-1:0]) * YP_W'(frame_height_r);
    y32        = 32'(y_full);
    show       = active_r && (len != '0) && (sheet_columns_r != 8'd0);
    load_ok    = 32'(item_r.entry_index) < 32'(MAX_FRAMES);
  end

  always_comb begin
    unique case (cw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_ITEM:   jump = !in_valid;
      C_NOT_TICK:  jump = (item_r.mode != MODE_TICK);
      C_SKIP_ADV:  jump = !active_r || (len == '0) || (frame_period_r == 16'd0);
      C_QUOT_ZERO: jump = (dnd_r == '0);
      C_NO_LOOP:   jump = !loop_enable_r;
      C_DIV_MORE:  jump = (div_cnt_r != DIV_CNT_W'(1));
      C_OUT_FULL:  jump = out_valid_r;
      default:     jump = 1'b0;
    endcase
    step_nxt = jump ? cw.target : step_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r          <= ST_TAKE;
      frame_period_r  <= 16'd0;
      loop_enable_r   <= 1'b1;
      clip_length_r   <= 7'd0;
      sheet_columns_r <= 8'd1;
      frame_width_r   <= 12'd0;
      frame_height_r  <= 12'd0;
      pos_r           <= '0;
      acc_r           <= 32'd0;
      active_r        <= 1'b0;
      div_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FRAME_PERIOD:  frame_period_r  <= cfg_data;
          CFG_LOOP_ENABLE:   loop_enable_r   <= cfg_data[0];
          CFG_CLIP_LENGTH:   clip_length_r   <= cfg_data[6:0];
          CFG_SHEET_COLUMNS: sheet_columns_r <= cfg_data[7:0];
          CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data[11:0];
          CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cw.op)
        OP_TAKE: begin
          if (in_valid) begin
            item_r <= in_data;
          end
        end
        OP_ADD_TIME: sum_r <= time_sat;
        OP_DIV_TIME: begin
          dnd_r     <= 33'(sum_r);
          dvs_r     <= frame_period_r;
          rem_r     <= '0;
          div_cnt_r <= DIV_N;
        end
        OP_DIV_STEP: begin
          dnd_r     <= {dnd_r[DND_W-2:0], trial_ok};
          rem_r     <= trial_ok ? trial[15:0] : {rem_r[14:0], dnd_r[DND_W-1]};
          div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
        end
        OP_STEPS: begin
          acc_r   <= 32'(rem_r);
          steps_r <= dnd_r[31:0];
        end
        OP_DIV_POS: begin
          dnd_r     <= pos_dnd;
          dvs_r     <= DVS_W'(len);
          rem_r     <= '0;
          div_cnt_r <= DIV_N;
        end
        OP_POS_WRAP: pos_r <= rem_r[POS_W-1:0];
        OP_STOP: begin
          prod_r <= prod_v;
          ge_r   <= steps_r >= 32'(stop_v);
        end
        OP_HOLD: begin
          if (ge_r) begin
            acc_r <= sum_r - 32'(prod_r);
            pos_r <= POS_W'(len - LEN_W'(1));
          end else begin
            pos_r <= POS_W'(pos32 + steps_r);
          end
        end
        OP_APPLY: begin
          if (item_r.mode == MODE_RESTART) begin
            pos_r    <= '0;
            acc_r    <= 32'd0;
            active_r <= 1'b1;
          end
        end
        OP_DIV_CELL: begin
          dnd_r     <= 33'(rd_r);
          dvs_r     <= {8'd0, sheet_columns_r};
          rem_r     <= '0;
          div_cnt_r <= DIV_N;
        end
        OP_MUL: begin
          x_prod_r <= x_full;
          y_prod_r <= y32[23:0];
        end
        OP_EMIT: begin
          if (!out_valid_r) begin
            out_valid_r          <= 1'b1;
            out_r.src_x          <= show ? x_prod_r : 20'd0;
            out_r.src_y          <= show ? y_prod_r : 24'd0;
            out_r.frame_position <= pos32[5:0];
            out_r.shown          <= show;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((cw.op == OP_APPLY) && (item_r.mode == MODE_LOAD) && load_ok) begin
      frame_table[POS_W'(item_r.entry_index)] <= cell32[CELL_BITS-1:0];
    end
    if (cw.op == OP_READ) begin
      rd_r <= frame_table[rd_addr];
    end
  end

  `SFS_ASSERT_NXT(a_take_leaves, clk, rst_n, in_valid && in_ready, !in_ready)
  `SFS_ASSERT_IMP(a_div_count, clk, rst_n, cw.op == OP_DIV_STEP, div_cnt_r != '0)
  `SFS_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, pos32 < 32'(MAX_FRAMES))
  `SFS_ASSERT_NXT(a_emit_loads, clk, rst_n, (cw.op == OP_EMIT) && !out_valid_r, out_valid_r)

endmodule

FILE: tb/sv/sprite_frame_sequencer_test.sv
// Self-checking bench for sprite_frame_sequencer: directed clip cases, then random
// phases of ticks, restarts, loads, unused codes; each result checked by a predictor.
// Depends on sfs_pkg and the sprite_frame_sequencer RTL.
module sprite_frame_sequencer_test;
  import sfs_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 480;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // register copies
  logic [15:0] period_q = '0;
  logic        loop_q = 1'b1;
  logic [6:0]  clip_len_q = '0;
  logic [7:0]  cols_q = 8'd1;
  logic [11:0] width_q = '0;
  logic [11:0] height_q = '0;

  // clip state copies
  logic [11:0] cell_table [MAX_FRAMES_DEF];
  logic [5:0]  pos_q = '0;
  logic [31:0] acc_q = '0;
  logic        active_q = 1'b0;

  in_item_t    pending_items [$];
  out_item_t   expected_rects [$];
  bit [63:0]   loaded_mask = '0;
  bit          no_gaps = 1'b0;
  int          outstanding = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned rects_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned random_items = 0;
  int unsigned clip_holds = 0;
  int unsigned loop_wraps = 0;
  int unsigned mode_seen [4] = '{0, 0, 0, 0};

  sprite_frame_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic out_item_t sequence_item(in_item_t it);
    out_item_t       rect;
    longint unsigned len, acc, steps, p, stop, cell_no;
    len = (clip_len_q > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : clip_len_q;
    mode_seen[it.mode]++;
    case (it.mode)
      MODE_TICK: begin
        if (active_q && len != 0 && period_q != 0) begin
          acc = 64'(acc_q) + it.elapsed;
          if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
          steps = acc / period_q;
          if (steps != 0) begin
            if (loop_q) begin
              p = pos_q;
              acc = acc - steps * period_q;
              if (p >= len) begin
                p = 0;
                steps = steps - 1;
              end
              if (p + steps >= len) loop_wraps++;
              pos_q = 6'((p + steps) % len);
            end else begin
              stop = (pos_q < len) ? len - pos_q : 1;
              if (steps >= stop) begin
                acc = acc - stop * period_q;
                pos_q = 6'(len - 1);
                clip_holds++;
              end else begin
                acc = acc - steps * period_q;
                pos_q = 6'(pos_q + steps);
              end
            end
          end
          acc_q = 32'(acc);
        end
      end
      MODE_RESTART: begin
        pos_q = '0;
        acc_q = '0;
        active_q = 1'b1;
      end
      MODE_LOAD: cell_table[it.entry_index] = it.entry_cell;
      default: ;
    endcase
    rect = '0;
    rect.frame_position = pos_q;
    if (active_q && len != 0 && cols_q != 0) begin
      cell_no = cell_table[(pos_q < len) ? pos_q : 6'(len - 1)];
      rect.src_x = 20'((cell_no % cols_q) * width_q);
      rect.src_y = 24'((cell_no / cols_q) * height_q);
      rect.shown = 1'b1;
    end
    return rect;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 140);
  endfunction

  function automatic int unsigned pick_field(int unsigned top, int unsigned near_top);
    int unsigned lim;
    lim = (near_top > top) ? top : near_top;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return top;
      2, 3, 4, 5, 6: return $urandom_range(1, lim);
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] mode, logic [15:0] elapsed,
                                     logic [5:0] slot, logic [11:0] cell_no);
    in_item_t it;
    it.mode = mode;
    it.elapsed = elapsed;
    it.entry_index = slot;
    it.entry_cell = cell_no;
    if (mode == MODE_LOAD) loaded_mask[slot] = 1'b1;
    pending_items = {pending_items, it};
    outstanding++;
  endfunction

  task automatic drain(input int unsigned tail);
    do @(posedge clk); while (outstanding > 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DAT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_PERIOD:  period_q   = 16'(value);
      CFG_LOOP_ENABLE:   loop_q     = 1'(value);
      CFG_CLIP_LENGTH:   clip_len_q = 7'(value);
      CFG_SHEET_COLUMNS: cols_q     = 8'(value);
      CFG_FRAME_WIDTH:   width_q    = 12'(value);
      CFG_FRAME_HEIGHT:  height_q   = 12'(value);
      default: ;
    endcase
    reg_writes++;
  endtask

  // load every slot the new clip can show, then reprogram while idle
  task automatic program_clip(input int unsigned period, input int unsigned loop_on,
                              input int unsigned len, input int unsigned cols,
                              input int unsigned w, input int unsigned h);
    int unsigned i, eff;
    eff = (len > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : len;
    for (i = 0; i < eff; i++)
      if (!loaded_mask[i]) queue_item(MODE_LOAD, 16'($urandom), 6'(i), 12'($urandom));
    drain(8);
    write_reg(CFG_FRAME_PERIOD, period);
    write_reg(CFG_LOOP_ENABLE, loop_on);
    write_reg(CFG_CLIP_LENGTH, len);
    write_reg(CFG_SHEET_COLUMNS, cols);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_rects = {expected_rects, sequence_item(in_data)};
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        outstanding--;
        if (expected_rects.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result x=%0d y=%0d pos=%0d shown=%0b", $time,
                   out_data.src_x, out_data.src_y, out_data.frame_position, out_data.shown);
        end else begin
          want = expected_rects.pop_front();
          rects_checked++;
          if (want.src_x !== out_data.src_x || want.src_y !== out_data.src_y ||
              want.frame_position !== out_data.frame_position ||
              want.shown !== out_data.shown) begin
            mismatch_count++;
            $display({"%0t: expected x=%0d y=%0d pos=%0d shown=%0b, ",
                      "got x=%0d y=%0d pos=%0d shown=%0b"},
                     $time, want.src_x, want.src_y, want.frame_position, want.shown,
                     out_data.src_x, out_data.src_y, out_data.frame_position, out_data.shown);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left <= pick_gap();
      end
    end
  end

  initial begin
    int unsigned n, i, r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // inactive tick, unused code at field maxima, empty clip, table edges
    queue_item(MODE_TICK, 16'hFFFF, 6'd0, 12'd0);
    queue_item(MODE_UNUSED, 16'hFFFF, 6'd63, 12'hFFF);
    queue_item(MODE_RESTART, 16'd0, 6'd0, 12'd0);
    queue_item(MODE_TICK, 16'hFFFF, 6'd0, 12'd0);
    queue_item(MODE_LOAD, 16'd0, 6'd63, 12'hFFF);
    queue_item(MODE_LOAD, 16'd0, 6'd0, 12'd0);
    queue_item(MODE_LOAD, 16'd0, 6'd1, 12'hFFF);
    queue_item(MODE_LOAD, 16'd0, 6'd2, 12'd2);
    queue_item(MODE_LOAD, 16'd0, 6'd3, 12'd1000);
    program_clip(1, 1, 4, 255, 4095, 4095);
    queue_item(MODE_RESTART, 16'd0, 6'd0, 12'd0);
    queue_item(MODE_TICK, 16'd0, 6'd0, 12'd0);
    queue_item(MODE_TICK, 16'd1, 6'd0, 12'd0);
    queue_item(MODE_TICK, 16'hFFFF, 6'd0, 12'd0);
    queue_item(MODE_TICK, 16'd2, 6'd0, 12'd0);
    queue_item(MODE_UNUSED, 16'd0, 6'd0, 12'd0);
    // shrink under the position, then wrap
    program_clip(100, 1, 2, 1, 7, 9);
    queue_item(MODE_UNUSED, 16'd0, 6'd0, 12'd0);
    queue_item(MODE_TICK, 16'd250, 6'd0, 12'd0);
    // paused, restart while running, no columns
    program_clip(0, 0, 4, 0, 4095, 4095);
    queue_item(MODE_TICK, 16'hFFFF, 6'd0, 12'd0);
    queue_item(MODE_RESTART, 16'd0, 6'd0, 12'd0);
    queue_item(MODE_UNUSED, 16'd0, 6'd0, 12'd0);
    // hold on the last frame with leftover time
    program_clip(3, 0, 4, 3, 4095, 4095);
    queue_item(MODE_TICK, 16'hFFFF, 6'd0, 12'd0);
    queue_item(MODE_TICK, 16'd1, 6'd0, 12'd0);
    queue_item(MODE_TICK, 16'hFFFF, 6'd0, 12'd0);
    program_clip(3, 0, 2, 16, 5, 5);
    queue_item(MODE_TICK, 16'd4, 6'd0, 12'd0);

    while (random_items < RANDOM_ITEMS) begin
      program_clip(pick_field(65535, 30), $urandom_range(0, 1), pick_field(127, 8),
                   pick_field(255, 12), pick_field(4095, 40), pick_field(4095, 40));
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 40);
      if ($urandom_range(0, 2) == 0) queue_item(MODE_RESTART, 16'($urandom), 6'($urandom),
                                                 12'($urandom));
      for (i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60)
          queue_item(MODE_TICK, 16'(pick_field(65535, 3 * period_q + 1)), 6'($urandom),
                     12'($urandom));
        else if (r < 70)
          queue_item(MODE_RESTART, 16'($urandom), 6'($urandom), 12'($urandom));
        else if (r < 93)
          queue_item(MODE_LOAD, 16'($urandom), 6'($urandom), 12'($urandom));
        else
          queue_item(MODE_UNUSED, 16'($urandom), 6'($urandom), 12'($urandom));
      end
      random_items += n;
    end

    drain(200);
    $display("Sent %0d ticks, %0d restarts, %0d loads and %0d unused-code items.",
             mode_seen[MODE_TICK], mode_seen[MODE_RESTART], mode_seen[MODE_LOAD],
             mode_seen[MODE_UNUSED]);
    $display("Checked %0d rectangles across %0d register writes, %0d holds, %0d wraps.",
             rects_checked, reg_writes, clip_holds, loop_wraps);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("%0t: run did not complete in time", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sfs_pkg.sv
rtl/sprite_frame_sequencer.sv
tb/sv/sprite_frame_sequencer_test.sv
